>>> rtl/rimac_pkg.sv
`default_nettype none
package rimac_pkg;
  localparam int QueueDepth = 16;
  localparam int AddrBits   = 16;
  localparam int PtrBits    = $clog2(QueueDepth);
  localparam int CntBits    = $clog2(QueueDepth + 1);
  localparam int TickBits   = 20;
  localparam int DelayBits  = 23;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 20;
  localparam logic [DelayBits-1:0] DelayMax = '1;
  localparam logic [AddrBits-1:0] AddrAll = '1;

  typedef enum logic [4:0] {
    OP_START = 5'd0, OP_WAKEUP = 5'd1, OP_CCA_TO = 5'd2, OP_WAIT_OVER = 5'd3,
    OP_BUZZ_TO = 5'd4, OP_DATA_TO = 5'd5, OP_ACK_TO = 5'd6, OP_SEND_BEACON = 5'd7,
    OP_SEND_BUZZ = 5'd8, OP_RESEND = 5'd9, OP_DATA_TX_OVER = 5'd10,
    OP_ACK_TX_OVER = 5'd11, OP_ACK_SEND = 5'd12, OP_RX_BEACON = 5'd13,
    OP_RX_BUZZ = 5'd14, OP_RX_DATA = 5'd15, OP_RX_ACK = 5'd16,
    OP_PHY_TX_OVER = 5'd17, OP_PHY_SWITCH = 5'd18, OP_UPPER = 5'd19
  } op_e;

  localparam logic [2:0] CfgOwn = 3'd0, CfgSlot = 3'd1, CfgCheck = 3'd2,
    CfgBuzz = 3'd3, CfgData = 3'd4, CfgMaxAtt = 3'd5, CfgQLimit = 3'd6,
    CfgUpper = 3'd7;

  localparam logic [1:0] RadNone = 2'd0, RadSleep = 2'd1, RadRx = 2'd2, RadTx = 2'd3;
  localparam logic [2:0] FrNone = 3'd0, FrBeacon = 3'd1, FrBuzz = 3'd2,
    FrData = 3'd3, FrAck = 3'd4;
  localparam logic [3:0] TNone = 4'd0, TWakeup = 4'd1, TCca = 4'd2,
    TWaitOver = 4'd3, TBuzz = 4'd4, TData = 4'd5, TAck = 4'd6,
    TSendBeacon = 4'd7, TSendBuzz = 4'd8, TResend = 4'd9,
    TDataTxOver = 4'd10, TAckTxOver = 4'd11, TSendAck = 4'd12;

  typedef struct packed {
    logic [AddrBits-1:0]  own_address;
    logic [TickBits-1:0]  slot_ticks;
    logic [TickBits-1:0]  check_ticks;
    logic [TickBits-1:0]  buzz_ticks;
    logic [TickBits-1:0]  data_ticks;
    logic [3:0]           max_attempts;
    logic [4:0]           queue_limit;
    logic [TickBits-1:0]  upper_wake_ticks;
  } cfg_t;

  typedef struct packed {
    logic [4:0]          operation;
    logic [AddrBits-1:0] frame_source;
    logic [AddrBits-1:0] frame_destination;
    logic [7:0]          random_fraction;
    logic                radio_in_tx;
  } in_t;

  typedef struct packed {
    logic [3:0]           mac_state_out;
    logic [1:0]           radio_command;
    logic [2:0]           frame_kind;
    logic [AddrBits-1:0]  frame_target;
    logic [3:0]           timer_select;
    logic [DelayBits-1:0] timer_delay;
    logic [11:0]          cancel_mask;
    logic                 deliver_up;
    logic                 queue_drop;
    logic [4:0]           queue_level;
    logic                 undefined_event;
  } out_t;

  function automatic logic [DelayBits-1:0] sat_delay(input logic [DelayBits+1:0] v);
    sat_delay = (|v[DelayBits+1:DelayBits]) ? DelayMax : v[DelayBits-1:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/rimac_if.sv
`default_nettype none
interface rimac_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rimac_cfg.sv
`default_nettype none
module rimac_cfg (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [rimac_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [rimac_pkg::CfgDataBits-1:0] cfg_data_i,
  output rimac_pkg::cfg_t cfg_o
);
  import rimac_pkg::*;
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address <= 16'd1;
      cfg_q.slot_ticks <= 20'd900;
      cfg_q.check_ticks <= 20'd100;
      cfg_q.buzz_ticks <= 20'd7;
      cfg_q.data_ticks <= 20'd20;
      cfg_q.max_attempts <= 4'd3;
      cfg_q.queue_limit <= 5'd10;
      cfg_q.upper_wake_ticks <= 20'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOwn:    cfg_q.own_address <= cfg_data_i[AddrBits-1:0];
        CfgSlot:   cfg_q.slot_ticks <= cfg_data_i;
        CfgCheck:  cfg_q.check_ticks <= cfg_data_i;
        CfgBuzz:   cfg_q.buzz_ticks <= cfg_data_i;
        CfgData:   cfg_q.data_ticks <= cfg_data_i;
        CfgMaxAtt: cfg_q.max_attempts <= cfg_data_i[3:0];
        CfgQLimit: cfg_q.queue_limit <= cfg_data_i[4:0];
        CfgUpper:  cfg_q.upper_wake_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

>>> rtl/rimac_core.sv
`default_nettype none
module rimac_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  rimac_pkg::cfg_t cfg_i,
  input  wire logic load_i,
  input  wire logic adv_i,
  input  rimac_pkg::in_t in_i,
  output logic valid_o,
  output rimac_pkg::out_t out_o
);
  import rimac_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT = 4'd0, ST_SLEEP = 4'd1, ST_CCA = 4'd2, ST_WAIT_BEACON = 4'd3,
    ST_SEND_BEACON = 4'd4, ST_WAIT_BUZZ = 4'd5, ST_SEND_BUZZ = 4'd6,
    ST_SEND_DATA = 4'd7, ST_WAIT_TX_OVER = 4'd8, ST_WAIT_ACK = 4'd9,
    ST_WAIT_DATA = 4'd10, ST_ACK_SEND = 4'd11, ST_WAIT_ACK_TX = 4'd12
  } state_e;

  state_e state_q, state_d;
  logic [AddrBits-1:0] fifo_mem [QueueDepth];
  logic [CntBits-1:0] count_q, count_d;
  logic [PtrBits-1:0] head_q, head_d;
  logic [3:0] att_q, att_d;
  logic ackp_q, ackp_d, wkp_q, wkp_d;
  logic [AddrBits-1:0] pdst_q, pdst_d, psrc_q, psrc_d;
  logic push;
  logic [PtrBits-1:0] tail;

  // event register and its valid bit
  in_t in_q;
  logic v1_q;
  logic step_en;
  assign step_en = v1_q && adv_i;
  assign valid_o = v1_q;

  // jitter products and delay sums from the registered event
  logic [DelayBits+1:0] rc, rslot, rup, busy, dat2, dat4, ackd, buz2;
  logic [27:0] p_check, p_slot, p_up;
  assign p_check = 28'(in_q.random_fraction) * 28'(cfg_i.check_ticks);
  assign p_slot  = 28'(in_q.random_fraction) * 28'(cfg_i.slot_ticks);
  assign p_up    = 28'(in_q.random_fraction) * 28'(cfg_i.upper_wake_ticks);
  assign rc    = 25'(p_check[27:8]);
  assign rslot = 25'(p_slot[27:8]);
  assign rup   = 25'(p_up[27:8]);
  assign busy  = 25'(cfg_i.slot_ticks) + 25'(p_check[27:8]);
  assign dat2  = {4'd0, cfg_i.data_ticks, 1'b0};
  assign dat4  = {3'd0, cfg_i.data_ticks, 2'b0};
  assign buz2  = {4'd0, cfg_i.buzz_ticks, 1'b0};
  assign ackd  = 25'({cfg_i.data_ticks, 1'b0}) + 25'(cfg_i.buzz_ticks)
                 + 25'({cfg_i.buzz_ticks, 1'b0});

  // registered read of the queue head
  logic [AddrBits-1:0] head_val;
  logic [PtrBits-1:0] rd_ptr;
  assign rd_ptr = step_en ? head_d : head_q;
  out_t o;
  logic [4:0] cap;
  logic [DelayBits+1:0] idle;

  always_comb begin
    state_d = state_q; count_d = count_q; head_d = head_q; att_d = att_q;
    ackp_d = ackp_q; wkp_d = wkp_q; pdst_d = pdst_q; psrc_d = psrc_q;
    push = 1'b0;
    tail = head_q + count_q[PtrBits-1:0];
    o = '0;
    cap = (cfg_i.queue_limit < 5'(QueueDepth)) ? cfg_i.queue_limit : 5'(QueueDepth);
    idle = (count_q != '0) ? rc : 25'(cfg_i.slot_ticks);
    if (in_q.operation == OP_WAKEUP) wkp_d = 1'b0;
    if (in_q.operation == OP_UPPER) begin
      if (5'(count_q) >= cap) o.queue_drop = 1'b1;
      else begin
        push = 1'b1;
        count_d = count_q + 1'b1;
        if (wkp_d && state_q == ST_SLEEP) begin
          o.cancel_mask[0] = 1'b1;
          o.timer_select = TWakeup; o.timer_delay = sat_delay(rup);
        end
      end
    end else if (in_q.operation == OP_PHY_TX_OVER) begin
      case (state_q)
        ST_SEND_BEACON: begin
          state_d = ST_WAIT_BUZZ; o.radio_command = RadRx;
          o.timer_select = TBuzz; o.timer_delay = sat_delay(buz2);
        end
        ST_SEND_BUZZ: begin state_d = ST_SEND_DATA; o.timer_select = TResend; end
        ST_WAIT_TX_OVER: o.timer_select = TDataTxOver;
        ST_WAIT_ACK_TX: o.timer_select = TAckTxOver;
        default: ;
      endcase
    end else if (in_q.operation == OP_PHY_SWITCH) begin
      if (in_q.radio_in_tx) begin
        case (state_q)
          ST_SEND_BEACON: o.timer_select = TSendBeacon;
          ST_SEND_BUZZ: o.timer_select = TSendBuzz;
          ST_ACK_SEND: begin
            o.timer_select = TSendAck; o.timer_delay = sat_delay(dat2);
          end
          ST_SEND_DATA: o.timer_select = TResend;
          default: ;
        endcase
      end
    end else if (in_q.operation <= OP_RX_ACK) begin
      unique case (state_q)
        ST_INIT: begin
          if (in_q.operation == OP_START) begin
            o.radio_command = RadSleep; state_d = ST_SLEEP;
            o.timer_select = TWakeup; o.timer_delay = sat_delay(rslot); wkp_d = 1'b1;
          end else o.undefined_event = 1'b1;
        end
        ST_SLEEP: begin
          if (in_q.operation == OP_WAKEUP) begin
            o.timer_select = TCca; o.timer_delay = sat_delay(25'(cfg_i.buzz_ticks));
            state_d = ST_CCA; o.radio_command = RadRx;
          end else if (in_q.operation == OP_RX_DATA) begin
            if (cfg_i.own_address == '0) begin
              o.cancel_mask[0] = 1'b1; wkp_d = 1'b0;
              o.cancel_mask[4] = 1'b1;
              o.radio_command = RadRx; state_d = ST_WAIT_DATA;
              if (in_q.frame_destination == cfg_i.own_address) begin
                state_d = ST_ACK_SEND; psrc_d = in_q.frame_source;
                o.radio_command = RadTx; o.deliver_up = 1'b1;
              end
            end
          end else if (in_q.operation == OP_RX_BUZZ &&
                       in_q.frame_destination == cfg_i.own_address) begin
            o.cancel_mask[0] = 1'b1; wkp_d = 1'b0;
            o.timer_select = TData; o.timer_delay = sat_delay(dat2);
            state_d = ST_WAIT_DATA; o.radio_command = RadRx;
          end
        end
        ST_WAIT_BEACON, ST_CCA: begin
          if (state_q == ST_WAIT_BEACON && in_q.operation == OP_WAIT_OVER) begin
            o.timer_select = TWakeup; o.timer_delay = sat_delay(rc); wkp_d = 1'b1;
            state_d = ST_SLEEP; o.radio_command = RadSleep;
          end else if (state_q == ST_CCA && in_q.operation == OP_CCA_TO) begin
            if (count_q != '0) begin
              state_d = ST_WAIT_BEACON;
              o.timer_select = TWaitOver; o.timer_delay = sat_delay(25'(cfg_i.slot_ticks));
            end else begin
              state_d = ST_SEND_BEACON; o.radio_command = RadTx;
            end
          end else if (in_q.operation == OP_RX_BEACON) begin
            if (count_q != '0) begin
              pdst_d = head_val;
              if (in_q.frame_source == head_val) begin
                state_d = ST_SEND_BUZZ; o.radio_command = RadTx;
                o.cancel_mask[2] = 1'b1; att_d = 4'd1;
                if (state_q == ST_CCA) o.cancel_mask[1] = 1'b1;
              end
            end
          end else if (in_q.operation == OP_RX_BUZZ || in_q.operation == OP_RX_DATA) begin
            if (state_q == ST_CCA) o.cancel_mask[1] = 1'b1;
            else o.cancel_mask[2] = 1'b1;
            o.timer_select = TWakeup; o.timer_delay = sat_delay(busy); wkp_d = 1'b1;
            state_d = ST_SLEEP; o.radio_command = RadSleep;
          end
        end
        ST_SEND_BUZZ: if (in_q.operation == OP_SEND_BUZZ) begin
          o.frame_kind = FrBuzz; o.frame_target = pdst_q;
        end
        ST_WAIT_BUZZ: begin
          if (in_q.operation == OP_RX_BUZZ) begin
            if (in_q.frame_destination == cfg_i.own_address) begin
              o.cancel_mask[3] = 1'b1;
              o.timer_select = TData; o.timer_delay = sat_delay(dat4);
              state_d = ST_WAIT_DATA;
            end
          end else if (in_q.operation == OP_BUZZ_TO) begin
            o.timer_select = TWakeup; wkp_d = 1'b1;
            o.timer_delay = sat_delay((count_q != '0) ? rc : busy);
            state_d = ST_SLEEP; o.radio_command = RadSleep;
          end
        end
        ST_SEND_BEACON: if (in_q.operation == OP_SEND_BEACON) begin
          o.frame_kind = FrBeacon; o.frame_target = AddrAll;
        end
        ST_SEND_DATA: if (in_q.operation == OP_RESEND) begin
          o.frame_kind = FrData;
          if (count_q != '0) begin pdst_d = head_val; o.frame_target = head_val; end
          else o.frame_target = pdst_q;
          ackp_d = 1'b1; state_d = ST_WAIT_TX_OVER;
        end
        ST_WAIT_TX_OVER: if (in_q.operation == OP_DATA_TX_OVER) begin
          state_d = ST_WAIT_ACK; o.radio_command = RadRx;
          o.timer_select = TAck; o.timer_delay = sat_delay(ackd);
        end
        ST_WAIT_ACK: begin
          if (in_q.operation == OP_ACK_TO) begin
            if (att_q < cfg_i.max_attempts) begin
              att_d = att_q + 4'd1; state_d = ST_SEND_DATA; o.radio_command = RadTx;
            end else begin
              if (ackp_q && count_q != '0) begin
                head_d = head_q + 1'b1; count_d = count_q - 1'b1;
              end
              o.timer_select = TWakeup; wkp_d = 1'b1;
              o.timer_delay = sat_delay((count_d != '0) ? rc : busy);
              state_d = ST_SLEEP; o.radio_command = RadSleep;
            end
          end else if (in_q.operation == OP_RX_ACK && in_q.frame_source == pdst_q) begin
            o.cancel_mask[5] = 1'b1;
            if (ackp_q && count_q != '0) begin
              head_d = head_q + 1'b1; count_d = count_q - 1'b1;
            end
            o.timer_select = TWakeup; wkp_d = 1'b1;
            o.timer_delay = sat_delay((count_d != '0) ? rc : 25'(cfg_i.slot_ticks));
            state_d = ST_SLEEP; o.radio_command = RadSleep; pdst_d = AddrAll;
          end
        end
        ST_WAIT_DATA: begin
          if (in_q.operation == OP_RX_DATA) begin
            o.cancel_mask[4] = 1'b1;
            if (in_q.frame_destination == cfg_i.own_address) begin
              state_d = ST_ACK_SEND; psrc_d = in_q.frame_source;
              o.radio_command = RadTx; o.deliver_up = 1'b1;
            end
          end else if (in_q.operation == OP_DATA_TO) begin
            o.timer_select = TWakeup; o.timer_delay = sat_delay(idle); wkp_d = 1'b1;
            state_d = ST_SLEEP; o.radio_command = RadSleep;
          end
        end
        ST_ACK_SEND: if (in_q.operation == OP_ACK_SEND) begin
          o.frame_kind = FrAck; o.frame_target = psrc_q; state_d = ST_WAIT_ACK_TX;
        end
        ST_WAIT_ACK_TX: if (in_q.operation == OP_ACK_TX_OVER) begin
          o.timer_select = TWakeup; o.timer_delay = sat_delay(idle); wkp_d = 1'b1;
          state_d = ST_SLEEP; o.radio_command = RadSleep; psrc_d = AddrAll;
        end
        default: ;
      endcase
    end
    // a sink wakeup cancel on upper packet clears pending then rearms
    if (in_q.operation == OP_UPPER && o.timer_select == TWakeup) wkp_d = 1'b1;
    o.mac_state_out = (state_d == ST_WAIT_ACK_TX) ? 4'(ST_ACK_SEND) : 4'(state_d);
    o.queue_level = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT; count_q <= '0; head_q <= '0; att_q <= '0;
      ackp_q <= 1'b0; wkp_q <= 1'b0; pdst_q <= AddrAll; psrc_q <= AddrAll;
      v1_q <= 1'b0; in_q <= '0; out_o <= '0;
    end else begin
      if (adv_i) v1_q <= load_i;
      if (load_i) in_q <= in_i;
      if (step_en) begin
        state_q <= state_d; count_q <= count_d; head_q <= head_d; att_q <= att_d;
        ackp_q <= ackp_d; wkp_q <= wkp_d; pdst_q <= pdst_d; psrc_q <= psrc_d;
        out_o <= o;
      end
    end
  end

  // a push into an empty queue lands at the head, so forward it
  always_ff @(posedge clk_i) begin
    if (step_en && push) fifo_mem[tail] <= in_q.frame_destination;
    if (step_en && push && tail == rd_ptr) head_val <= in_q.frame_destination;
    else head_val <= fifo_mem[rd_ptr];
  end
endmodule
`default_nettype wire

>>> rtl/receiver_initiated_mac_fsm.sv
`default_nettype none
// Pipeline: an input transfer loads the event register, the decision logic then loads
//   the result register, and the result is held on the output until it is taken.
// Throughput: one event per cycle; both registers advance only when the result
//   register is free or being drained, so back pressure stalls the input as well.
// Reset: rst_ni async active low; state INIT, queue empty, peers broadcast,
//   registers at defaults. Queue storage is not cleared.
module receiver_initiated_mac_fsm (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [rimac_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [rimac_pkg::CfgDataBits-1:0] cfg_data_i,
  rimac_if.sink   in_if,
  rimac_if.source out_if
);
  import rimac_pkg::*;
  cfg_t cfg;
  in_t in_w;
  out_t res;
  logic ev_valid, ovalid_q, adv;

  assign in_w = in_if.data;
  // advance everything when output slot empties or is taken
  assign adv = !ovalid_q || out_if.ready;
  assign in_if.ready = adv;

  rimac_cfg u_cfg (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg));

  // core holds the event register and the result register; hold both on back pressure
  rimac_core u_core (.clk_i, .rst_ni, .cfg_i(cfg),
    .load_i(in_if.valid && adv), .adv_i(adv), .in_i(in_w),
    .valid_o(ev_valid), .out_o(res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (adv) begin
      ovalid_q <= ev_valid;
    end
  end
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res;
endmodule
`default_nettype wire

>>> rtl/rimac_checker.sv
`default_nettype none
module rimac_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [rimac_pkg::DelayBits-1:0] tdel_i,
  input wire logic [3:0] tsel_i,
  input wire logic [4:0] qlev_i
);
  a_nodelay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tsel_i == 4'd0 |-> tdel_i == '0) else $error("delay without timer");
  a_qlev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> qlev_i <= 5'd16) else $error("queue level range");
  a_tsel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tsel_i <= 4'd12) else $error("timer range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tdel_i) && $stable(tsel_i))
    else $error("result not held");
endmodule
bind receiver_initiated_mac_fsm rimac_checker u_chk (.clk_i, .rst_ni,
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .tdel_i(out_if.data[rimac_pkg::DelayBits+19:20]),
  .tsel_i(out_if.data[rimac_pkg::DelayBits+23:rimac_pkg::DelayBits+20]),
  .qlev_i(out_if.data[5:1]));
`default_nettype wire
